FILE: rtl/snvm_pkg.sv
// Shared types and constants of the square/noise voice mixer.
// No dependencies; every other file of the block depends on this package.
package snvm_pkg;

  localparam int unsigned StepW      = 16;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned ContribW   = 10;
  localparam int unsigned MixW       = 12;
  localparam int unsigned NumSquare  = 3;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned TickSlots  = 2;

  localparam logic [ByteW-1:0] TickDiv      = 8'd8;
  localparam int unsigned      TickSources  = 2;
  localparam logic [ByteW-1:0] CountTop     = 8'd255;
  localparam logic [StepW-1:0] NoiseSeed    = 16'h0001;
  localparam logic [ByteW-1:0] NoiseNegHigh = 8'd128;
  localparam logic signed [MixW-1:0] MixCentre = 12'sd512;

  typedef logic [StepW-1:0]           step_t;
  typedef logic [ByteW-1:0]           byte_t;
  typedef logic signed [ContribW-1:0] contrib_t;
  typedef logic signed [MixW-1:0]     mix_t;

  typedef enum logic [CfgIdxW-1:0] {
    RegTickPresetA = 3'd0,
    RegTickPresetB = 3'd1,
    RegTickEnableA = 3'd2,
    RegTickEnableB = 3'd3
  } snvm_reg_e;

  // tick counter settings and enable-write strobes, top level -> tick unit
  typedef struct packed {
    logic [TickSlots-1:0][ByteW-1:0] preset;
    logic [TickSlots-1:0]            enable;
    logic [TickSlots-1:0]            clear;
  } tick_cfg_t;

  // +level or -level as a signed contribution
  function automatic contrib_t signed_level(input byte_t level, input logic neg);
    contrib_t mag;
    mag = contrib_t'({2'b00, level});
    return neg ? -mag : mag;
  endfunction

endpackage

FILE: rtl/snvm_intf.sv
// Valid/ready channel interfaces of the mixer: sample input, mix output, config writes.
// Depends on snvm_pkg for payload types.
interface snvm_in_if;
  logic               valid;
  logic               ready;
  snvm_pkg::step_t    step_a;
  snvm_pkg::step_t    step_b;
  snvm_pkg::step_t    step_c;
  snvm_pkg::byte_t    duty_a;
  snvm_pkg::byte_t    duty_b;
  snvm_pkg::byte_t    duty_c;
  snvm_pkg::byte_t    level_a;
  snvm_pkg::byte_t    level_b;
  snvm_pkg::byte_t    level_c;
  snvm_pkg::byte_t    noise_level;

  modport source (output valid, step_a, step_b, step_c, duty_a, duty_b, duty_c,
                  level_a, level_b, level_c, noise_level, input ready);
  modport sink   (input valid, step_a, step_b, step_c, duty_a, duty_b, duty_c,
                  level_a, level_b, level_c, noise_level, output ready);
endinterface

interface snvm_out_if;
  logic            valid;
  logic            ready;
  snvm_pkg::mix_t  mix_value;
  logic            tick_a;
  logic            tick_b;

  modport source (output valid, mix_value, tick_a, tick_b, input ready);
  modport sink   (input valid, mix_value, tick_a, tick_b, output ready);
endinterface

interface snvm_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [snvm_pkg::CfgIdxW-1:0]        index;
  snvm_pkg::byte_t                     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/snvm_square_lane.sv
// One square voice lane: 16-bit phase accumulator and duty compare.
// Depends on snvm_pkg.
module snvm_square_lane (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  snvm_pkg::step_t    step_i,
  input  snvm_pkg::byte_t    duty_i,
  input  snvm_pkg::byte_t    level_i,
  output snvm_pkg::contrib_t contrib_o
);
  import snvm_pkg::*;

  step_t phase_q, phase_d;

  assign phase_d   = phase_q + step_i;
  // positive while the high byte sits below the duty threshold
  assign contrib_o = signed_level(level_i, !(phase_d[StepW-1 -: ByteW] < duty_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
    end
  end

endmodule

FILE: rtl/snvm_noise_lane.sv
// Noise voice lane: 16-bit LFSR stepped once per sample beat.
// Depends on snvm_pkg.
module snvm_noise_lane (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  snvm_pkg::byte_t    level_i,
  output snvm_pkg::contrib_t contrib_o
);
  import snvm_pkg::*;

  step_t lfsr_q, lfsr_d;
  byte_t high;
  logic  neg;

  always_comb begin
    lfsr_d    = {lfsr_q[StepW-2:0], 1'b0};
    lfsr_d[0] = lfsr_d[StepW-1] ^ lfsr_d[StepW-2];
  end

  assign high      = lfsr_d[StepW-1 -: ByteW];
  assign neg       = (high != '0) && (high <= NoiseNegHigh);
  assign contrib_o = signed_level(level_i, neg);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= NoiseSeed;
    end else if (advance_i) begin
      lfsr_q <= lfsr_d;
    end
  end

  // seed is non-zero and the feedback keeps it so
  a_lfsr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_q != '0) else $error("noise LFSR stuck at zero");

endmodule

FILE: rtl/snvm_tick_unit.sv
// Sample prescaler and the two tick counters with their reload/pin rule.
// Depends on snvm_pkg.
module snvm_tick_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           advance_i,
  input  snvm_pkg::tick_cfg_t            cfg_i,
  output logic [snvm_pkg::TickSlots-1:0] flag_o
);
  import snvm_pkg::*;

  byte_t                 prescale_q, prescale_d, prescale_dec;
  byte_t [TickSlots-1:0] count_q, count_d, count_dec;
  logic                  wrapped;

  always_comb begin
    prescale_d   = prescale_q;
    count_d      = count_q;
    flag_o       = '0;
    wrapped      = 1'b0;
    prescale_dec = prescale_q - 8'd1;
    count_dec    = count_q;
    if (advance_i) begin
      prescale_d = prescale_dec;
      if (prescale_dec == '0) begin
        prescale_d = TickDiv;
        for (int n = 0; n < TickSlots; n++) begin
          if (n < TickSources) begin
            if (count_q[n] == '0) wrapped = 1'b1;
            count_dec[n] = count_q[n] - 8'd1;
            count_d[n]   = count_dec[n];
          end
        end
        if (wrapped) begin
          for (int n = 0; n < TickSlots; n++) begin
            if (n < TickSources) begin
              if (count_dec[n] != CountTop) begin
                if (!cfg_i.enable[n]) count_d[n] = CountTop;
              end else begin
                flag_o[n]  = cfg_i.enable[n];
                count_d[n] = cfg_i.preset[n];
              end
            end
          end
        end
      end
    end
    // enabling a source restarts its counter
    for (int n = 0; n < TickSlots; n++) begin
      if (cfg_i.clear[n]) count_d[n] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q <= '0;
      count_q    <= '0;
    end else begin
      prescale_q <= prescale_d;
      count_q    <= count_d;
    end
  end

  a_flag_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flag_o & ~cfg_i.enable) == '0) else $error("tick flag on disabled source");

  a_flag_needs_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |-> flag_o == '0) else $error("tick flag without sample beat");

endmodule

FILE: rtl/square_noise_voice_mixer_unit.sv
// Top level of the square/noise voice mixer: lanes, tick unit, merge and output register.
// Depends on snvm_pkg, snvm_intf, snvm_square_lane, snvm_noise_lane, snvm_tick_unit.
//
// Usage
//   in_i  : one beat per audio sample, carrying the three square voice settings
//           (step, duty, level) and the noise level.
//   out_o : one beat per input beat: mix_value = 512 + four signed voice
//           contributions (PWM compare value), plus the two tick flags.
//   cfg_i : register writes (tick presets and enables), always ready; write
//           only while no sample is in flight. Writing an enable with bit 0
//           set restarts that tick counter at zero.
// Throughput
//   Three square lanes and the noise lane evaluate one sample in parallel; the
//   merge adder and tick unit sit in the same cycle, and the result lands in
//   the output register, so one sample per cycle is sustained while the
//   receiver keeps out_o.ready high. The output register is the only stage.
// Reset
//   rst_ni clears phases, prescaler, counters, config and out_valid_q; the LFSR loads 1.
//   The first prescaler event comes after 256 samples.
// Back-pressure
//   in_i.ready stays high while the output register is empty or being drained;
//   when the receiver stalls with a result held, input stalls too.
module square_noise_voice_mixer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  snvm_in_if.sink     in_i,
  snvm_out_if.source  out_o,
  snvm_cfg_if.sink    cfg_i
);
  import snvm_pkg::*;

  logic                 accept;
  logic                 cfg_write;
  contrib_t [NumSquare-1:0] sq_contrib;
  contrib_t             noise_contrib;
  mix_t                 mix_d;
  logic [TickSlots-1:0] flag;
  tick_cfg_t            tick_cfg;

  byte_t [TickSlots-1:0] preset_q;
  logic  [TickSlots-1:0] enable_q;

  logic                  out_valid_q;
  mix_t                  mix_q;
  logic [TickSlots-1:0]  flag_q;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign accept      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_write   = cfg_i.valid;

  // --- config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preset_q <= '0;
      enable_q <= '0;
    end else if (cfg_write) begin
      case (cfg_i.index)
        RegTickPresetA: preset_q[0] <= cfg_i.data;
        RegTickPresetB: preset_q[1] <= cfg_i.data;
        RegTickEnableA: enable_q[0] <= cfg_i.data[0];
        RegTickEnableB: enable_q[1] <= cfg_i.data[0];
        default: ;  // unknown index ignored
      endcase
    end
  end

  assign tick_cfg.preset   = preset_q;
  assign tick_cfg.enable   = enable_q;
  assign tick_cfg.clear[0] = cfg_write && (cfg_i.index == RegTickEnableA) && cfg_i.data[0];
  assign tick_cfg.clear[1] = cfg_write && (cfg_i.index == RegTickEnableB) && cfg_i.data[0];

  // --- voice lanes
  snvm_square_lane u_lane_a (
    .clk_i, .rst_ni, .advance_i(accept),
    .step_i(in_i.step_a), .duty_i(in_i.duty_a), .level_i(in_i.level_a),
    .contrib_o(sq_contrib[0])
  );
  snvm_square_lane u_lane_b (
    .clk_i, .rst_ni, .advance_i(accept),
    .step_i(in_i.step_b), .duty_i(in_i.duty_b), .level_i(in_i.level_b),
    .contrib_o(sq_contrib[1])
  );
  snvm_square_lane u_lane_c (
    .clk_i, .rst_ni, .advance_i(accept),
    .step_i(in_i.step_c), .duty_i(in_i.duty_c), .level_i(in_i.level_c),
    .contrib_o(sq_contrib[2])
  );
  snvm_noise_lane u_noise (
    .clk_i, .rst_ni, .advance_i(accept),
    .level_i(in_i.noise_level), .contrib_o(noise_contrib)
  );

  snvm_tick_unit u_tick (
    .clk_i, .rst_ni, .advance_i(accept), .cfg_i(tick_cfg), .flag_o(flag)
  );

  // --- merge: centre plus four contributions, no wrap within 12 bits
  always_comb begin
    mix_d = MixCentre + mix_t'(noise_contrib);
    for (int v = 0; v < NumSquare; v++) begin
      mix_d = mix_d + mix_t'(sq_contrib[v]);
    end
  end

  // --- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mix_q  <= mix_d;
      flag_q <= flag;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.mix_value = mix_q;
  assign out_o.tick_a    = flag_q[0];
  assign out_o.tick_b    = flag_q[1];

  a_accept_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q) else $error("accepted sample produced no output beat");

endmodule
